/* rtl/u8d_pkg.sv */
// Shared widths, sequence lengths and the result type of the UTF-8 stream decoder.
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;
    localparam int CONT_W = 6;

    // Sequence lengths as they appear on the result and in the length register.
    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;
    localparam logic [LEN_W-1:0] LEN_FIVE  = 3'd5;
    localparam logic [LEN_W-1:0] LEN_SIX   = 3'd6;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             bad_lead;
    } t_result;

endpackage

/* rtl/u8d_if.sv */
// Valid/ready channel interfaces for the byte input and the code point output.
interface u8d_byte_if;
    import u8d_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if;
    import u8d_pkg::*;

    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [LEN_W-1:0] seq_length;
    logic             bad_lead;

    modport source (output valid, output code_point, output seq_length, output bad_lead,
                    input ready);
    modport sink   (input valid, input code_point, input seq_length, input bad_lead,
                    output ready);
endinterface

/* rtl/utf8_stream_decoder.sv */
// The last byte of a sequence is registered in the input register; its result is registered in the output register.
// One byte per cycle while results have room; the input and output registers each hold one transfer.
// A sequence of n bytes gives one result after its n-th byte, so results come at most one a cycle.
// Reset (synchronous, active low) empties both registers and clears the sequence state.
// Bytes that give no result pass through without waiting for the output register.
module utf8_stream_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8d_byte_if.sink  i_byte_ch,
    u8d_cp_if.source  o_cp_ch
);
    import u8d_pkg::*;

    // Input register: holds one accepted byte until the decode stage takes it.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Sequence state: continuation bytes still expected, bits gathered so far
    // and the length of the sequence in progress.
    logic [LEN_W-1:0]  r_bytes_left, n_bytes_left;
    logic [CP_W-1:0]   r_accum,      n_accum;
    logic [LEN_W-1:0]  r_total_len,  n_total_len;

    // Result register.
    logic              r_out_valid;
    t_result           r_out;

    logic              res_hit;
    t_result           n_res;
    logic              out_free;
    logic              advance;
    logic              load_out;

    // The output register can take a new result when it is empty or being drained.
    assign out_free   = !r_out_valid || o_cp_ch.ready;
    // The held byte is consumed when it either gives no result or the result has room.
    assign advance    = r_in_valid && (!res_hit || out_free);
    assign load_out   = advance && res_hit;

    assign i_byte_ch.ready = !r_in_valid || advance;

    // Decode of one byte against the current sequence state.
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_accum      = r_accum;
        n_total_len  = r_total_len;
        res_hit      = 1'b0;
        n_res        = '0;

        if (r_bytes_left != '0) begin
            // Inside a sequence every byte gives its low six bits, checked or not.
            n_accum      = {r_accum[CP_W-CONT_W-1:0], r_in_byte[CONT_W-1:0]};
            n_bytes_left = r_bytes_left - 1'b1;
            if (r_bytes_left == LEN_ONE) begin
                res_hit          = 1'b1;
                n_res.code_point = n_accum;
                n_res.seq_length = r_total_len;
            end
        end else begin
            case (r_in_byte) inside
                8'b0???????, 8'b10??????: begin
                    // ASCII, and a stray continuation byte, stand for themselves.
                    res_hit          = 1'b1;
                    n_res.code_point = CP_W'(r_in_byte);
                    n_res.seq_length = LEN_ONE;
                end
                8'b1111110?: begin
                    n_accum      = CP_W'(r_in_byte[0]);
                    n_total_len  = LEN_SIX;
                    n_bytes_left = LEN_FIVE;
                end
                8'b111110??: begin
                    n_accum      = CP_W'(r_in_byte[1:0]);
                    n_total_len  = LEN_FIVE;
                    n_bytes_left = LEN_FOUR;
                end
                8'b11110???: begin
                    n_accum      = CP_W'(r_in_byte[2:0]);
                    n_total_len  = LEN_FOUR;
                    n_bytes_left = LEN_THREE;
                end
                8'b1110????: begin
                    n_accum      = CP_W'(r_in_byte[3:0]);
                    n_total_len  = LEN_THREE;
                    n_bytes_left = LEN_TWO;
                end
                8'b110?????: begin
                    n_accum      = CP_W'(r_in_byte[4:0]);
                    n_total_len  = LEN_TWO;
                    n_bytes_left = LEN_ONE;
                end
                default: begin
                    // 0xFE and 0xFF: flagged, consumed, and the stream carries on.
                    res_hit          = 1'b1;
                    n_res.seq_length = LEN_ONE;
                    n_res.bad_lead   = 1'b1;
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte_ch.ready) begin
            r_in_valid <= i_byte_ch.valid;
        end
        if (i_byte_ch.valid && i_byte_ch.ready) begin
            r_in_byte <= i_byte_ch.in_byte;
        end
    end

    // Sequence state moves only when the held byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_accum      <= '0;
            r_total_len  <= '0;
        end else if (advance) begin
            r_bytes_left <= n_bytes_left;
            r_accum      <= n_accum;
            r_total_len  <= n_total_len;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= load_out || (r_out_valid && !o_cp_ch.ready);
        end
        if (load_out) begin
            r_out <= n_res;
        end
    end

    assign o_cp_ch.valid      = r_out_valid;
    assign o_cp_ch.code_point = r_out.code_point;
    assign o_cp_ch.seq_length = r_out.seq_length;
    assign o_cp_ch.bad_lead   = r_out.bad_lead;

`ifndef SYNTHESIS
    // A flagged lead byte always yields a zero, one-byte result.
    a_bad_lead_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.bad_lead |-> r_out.code_point == '0 && r_out.seq_length == LEN_ONE)
        else $error("bad lead result is not zero with length one");

    // While a sequence is open, fewer bytes remain than its total length.
    a_left_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left != '0 |-> r_total_len > r_bytes_left && r_total_len <= LEN_SIX)
        else $error("sequence counters inconsistent");

    // A multi-byte result is loaded only by the last byte of its sequence.
    a_multi_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && n_res.seq_length != LEN_ONE |-> r_bytes_left == LEN_ONE)
        else $error("multi-byte result loaded before the sequence ended");

    // A result that is held back stays unchanged until its transfer.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_cp_ch.ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid straight after reset");
`endif

endmodule
